[rtl/core/skf_pkg.sv]
`default_nettype none

package skf_pkg;

   // Widths of the Q16.16 words, the Q1.16 gain and the shared multiplier.
   localparam int DataWidth     = 32;
   localparam int GainWidth     = 17;
   localparam int MagWidth      = DataWidth + 1;
   localparam int ProdWidth     = GainWidth + MagWidth;
   localparam int DivSteps      = GainWidth;
   localparam int DivCountWidth = 5;
   localparam int CsrIndexWidth = 1;

   localparam logic [GainWidth-1:0] GainOne = GainWidth'(65536);

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_PROCESS_NOISE = 1'b0,
      CSR_MEASURE_NOISE = 1'b1
   } skf_csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREDICT,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_MUL_EST,
      ST_MUL_COV,
      ST_UPDATE
   } skf_state_type;

   typedef struct packed {
      logic start;
   } skf_div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } skf_div_sts_type;

endpackage

`default_nettype wire

[rtl/core/skf_divider.sv]
`default_nettype none

// Restoring divider for the gain: predicted * 2^16 / denom, one quotient bit per cycle.
module skf_divider (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire skf_pkg::skf_div_ctl_type               div_ctl,
   input  wire logic [skf_pkg::DataWidth-1:0]          div_predicted,
   input  wire logic [skf_pkg::MagWidth-1:0]           div_denom,
   output skf_pkg::skf_div_sts_type                    div_sts,
   output logic [skf_pkg::GainWidth-1:0]               div_quotient
);

   logic [skf_pkg::MagWidth-1:0]      rem_ff, rem_in;
   logic [skf_pkg::MagWidth-1:0]      denom_ff, denom_in;
   logic [skf_pkg::GainWidth-1:0]     quo_ff, quo_in;
   logic                              feed_ff, feed_in;
   logic [skf_pkg::DivCountWidth-1:0] cnt_ff, cnt_in;
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;

   logic [skf_pkg::MagWidth:0]        shifted;
   logic [skf_pkg::MagWidth:0]        trial;
   logic                              fits;

   // The quotient never exceeds 2^16, so the partial remainder can start
   // at the dividend shifted down by the quotient width.
   assign shifted = {rem_ff, feed_ff};
   assign trial   = shifted - {1'b0, denom_ff};
   assign fits    = shifted >= {1'b0, denom_ff};

   always_comb begin
      rem_in   = rem_ff;
      denom_in = denom_ff;
      quo_in   = quo_ff;
      feed_in  = feed_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (div_ctl.start) begin
         rem_in   = {2'b00, div_predicted[skf_pkg::DataWidth-1:1]};
         feed_in  = div_predicted[0];
         denom_in = div_denom;
         quo_in   = '0;
         cnt_in   = skf_pkg::DivCountWidth'(skf_pkg::DivSteps);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? trial[skf_pkg::MagWidth-1:0] : shifted[skf_pkg::MagWidth-1:0];
         quo_in  = {quo_ff[skf_pkg::GainWidth-2:0], fits};
         feed_in = 1'b0;
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == skf_pkg::DivCountWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      denom_ff <= denom_in;
      quo_ff   <= quo_in;
      feed_ff  <= feed_in;
   end

   assign div_sts.busy = busy_ff;
   assign div_sts.done = done_ff;
   assign div_quotient = quo_ff;

   a_no_start_while_busy : assert property (@(posedge clock) disable iff (reset)
      div_ctl.start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_ends_busy : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("divider done without a finished run");

   a_busy_count : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0)
      else $error("divider busy with an empty step count");

endmodule

`default_nettype wire

[rtl/core/scalar_kalman_filter.sv]
`default_nettype none

// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_sample   signed Q16.16
// rsp       out        rsp_valid/rsp_stall  rsp_estimate signed Q16.16
// csr       in         csr_write            csr_index, csr_wdata (unsigned Q16.16)
//
// A request passes through prediction, divider launch, the gain divider
// (17 quotient steps and its done flag), two multiplies and update to the
// result register; the input reopens as the result register loads. A zero
// denominator skips the divider. Reset is synchronous and restores both
// noise registers, the estimate and the covariance. A stalled result holds
// the block in its update step.

module scalar_kalman_filter (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic signed [skf_pkg::DataWidth-1:0]   req_sample,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic signed [skf_pkg::DataWidth-1:0]        rsp_estimate,
   input  wire logic                                   csr_write,
   input  wire logic [skf_pkg::CsrIndexWidth-1:0]      csr_index,
   input  wire logic [skf_pkg::DataWidth-1:0]          csr_wdata
);

   skf_pkg::skf_state_type          state_ff, state_in;

   // Configuration and filter state.
   logic [skf_pkg::DataWidth-1:0]   pn_ff, pn_in;
   logic [skf_pkg::DataWidth-1:0]   mn_ff, mn_in;
   logic [skf_pkg::DataWidth-1:0]   est_ff, est_in;
   logic [skf_pkg::DataWidth-1:0]   cov_ff, cov_in;

   // Working registers for one request.
   logic [skf_pkg::DataWidth-1:0]   smp_ff, smp_in;
   logic [skf_pkg::DataWidth-1:0]   pred_ff, pred_in;
   logic [skf_pkg::MagWidth-1:0]    diff_ff, diff_in;
   logic [skf_pkg::MagWidth-1:0]    mag_ff, mag_in;
   logic [skf_pkg::GainWidth-1:0]   gain_ff, gain_in;
   logic [skf_pkg::ProdWidth-1:0]   prod_ff, prod_in;

   // Result register.
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [skf_pkg::DataWidth-1:0]   rsp_est_ff, rsp_est_in;

   // Shared multiplier operands.
   logic [skf_pkg::GainWidth-1:0]   mul_a;
   logic [skf_pkg::MagWidth-1:0]    mul_b;
   logic [skf_pkg::ProdWidth-1:0]   mul_p;

   logic [skf_pkg::MagWidth-1:0]    pred_sum;
   logic [skf_pkg::MagWidth-1:0]    denom;
   logic [skf_pkg::MagWidth-1:0]    corr;
   logic [skf_pkg::MagWidth:0]      est_ext;
   logic [skf_pkg::MagWidth:0]      est_next;
   logic                            rsp_free;

   skf_pkg::skf_div_ctl_type        div_ctl;
   skf_pkg::skf_div_sts_type        div_sts;
   logic [skf_pkg::GainWidth-1:0]   div_quotient;

   assign pred_sum = {1'b0, cov_ff} + {1'b0, pn_ff};
   assign denom    = {1'b0, pred_ff} + {1'b0, mn_ff};
   assign mul_p    = skf_pkg::ProdWidth'(mul_a) * skf_pkg::ProdWidth'(mul_b);

   // The correction is at most the innovation magnitude, so the new
   // estimate always lands between the old one and the sample.
   assign corr     = prod_ff[skf_pkg::ProdWidth-2:16];
   assign est_ext  = {{2{est_ff[skf_pkg::DataWidth-1]}}, est_ff};
   assign est_next = diff_ff[skf_pkg::MagWidth-1] ? est_ext - {1'b0, corr}
                                                  : est_ext + {1'b0, corr};

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   skf_divider u_divider (
      .clock         (clock),
      .reset         (reset),
      .div_ctl       (div_ctl),
      .div_predicted (pred_ff),
      .div_denom     (denom),
      .div_sts       (div_sts),
      .div_quotient  (div_quotient)
   );

   always_comb begin
      state_in     = state_ff;
      pn_in        = pn_ff;
      mn_in        = mn_ff;
      est_in       = est_ff;
      cov_in       = cov_ff;
      smp_in       = smp_ff;
      pred_in      = pred_ff;
      diff_in      = diff_ff;
      mag_in       = mag_ff;
      gain_in      = gain_ff;
      prod_in      = prod_ff;
      rsp_est_in   = rsp_est_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      div_ctl      = '0;
      mul_a        = gain_ff;
      mul_b        = mag_ff;
      req_stall    = 1'b1;

      // The user must write configuration only while the block is idle; the block itself does not enforce it.
      if (csr_write) begin
         unique case (skf_pkg::skf_csr_index_type'(csr_index))
            skf_pkg::CSR_PROCESS_NOISE: pn_in = csr_wdata;
            skf_pkg::CSR_MEASURE_NOISE: mn_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         skf_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               smp_in   = req_sample;
               state_in = skf_pkg::ST_PREDICT;
            end
         end
         skf_pkg::ST_PREDICT: begin
            // Predicted covariance saturates at the largest Q16.16 value.
            pred_in  = pred_sum[skf_pkg::MagWidth-1] ? '1 : pred_sum[skf_pkg::DataWidth-1:0];
            diff_in  = {smp_ff[skf_pkg::DataWidth-1], smp_ff}
                     - {est_ff[skf_pkg::DataWidth-1], est_ff};
            state_in = skf_pkg::ST_DIV_START;
         end
         skf_pkg::ST_DIV_START: begin
            mag_in = diff_ff[skf_pkg::MagWidth-1] ? -diff_ff : diff_ff;
            // Both terms zero means no uncertainty anywhere: the gain is one.
            if (denom == '0) begin
               gain_in  = skf_pkg::GainOne;
               state_in = skf_pkg::ST_MUL_EST;
            end else begin
               div_ctl.start = 1'b1;
               state_in      = skf_pkg::ST_DIV_WAIT;
            end
         end
         skf_pkg::ST_DIV_WAIT: begin
            if (div_sts.done) begin
               gain_in  = div_quotient;
               state_in = skf_pkg::ST_MUL_EST;
            end
         end
         skf_pkg::ST_MUL_EST: begin
            prod_in  = mul_p;
            state_in = skf_pkg::ST_MUL_COV;
         end
         skf_pkg::ST_MUL_COV: begin
            est_in   = est_next[skf_pkg::DataWidth-1:0];
            mul_a    = skf_pkg::GainOne - gain_ff;
            mul_b    = {1'b0, pred_ff};
            prod_in  = mul_p;
            state_in = skf_pkg::ST_UPDATE;
         end
         skf_pkg::ST_UPDATE: begin
            if (rsp_free) begin
               cov_in       = prod_ff[skf_pkg::DataWidth+15:16];
               rsp_est_in   = est_ff;
               rsp_valid_in = 1'b1;
               state_in     = skf_pkg::ST_IDLE;
            end
         end
         default: state_in = skf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skf_pkg::ST_IDLE;
         pn_ff        <= skf_pkg::DataWidth'(66);
         mn_ff        <= skf_pkg::DataWidth'(65536);
         est_ff       <= '0;
         cov_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pn_ff        <= pn_in;
         mn_ff        <= mn_in;
         est_ff       <= est_in;
         cov_ff       <= cov_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff     <= smp_in;
      pred_ff    <= pred_in;
      diff_ff    <= diff_in;
      mag_ff     <= mag_in;
      gain_ff    <= gain_in;
      prod_ff    <= prod_in;
      rsp_est_ff <= rsp_est_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_estimate = rsp_est_ff;

   a_gain_bounded : assert property (@(posedge clock) disable iff (reset)
      state_ff == skf_pkg::ST_MUL_EST |-> gain_ff <= skf_pkg::GainOne)
      else $error("gain above one");

   a_cov_shrinks : assert property (@(posedge clock) disable iff (reset)
      state_ff == skf_pkg::ST_UPDATE && rsp_free |=> cov_ff <= $past(pred_ff))
      else $error("updated covariance exceeds the prediction");

   a_result_from_update : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == skf_pkg::ST_UPDATE)
      else $error("result raised outside the update step");

   a_divider_only_waited : assert property (@(posedge clock) disable iff (reset)
      div_sts.busy |-> state_ff == skf_pkg::ST_DIV_WAIT)
      else $error("divider running outside the gain step");

endmodule

`default_nettype wire
